### sv/rotate_in_place_heading_controller_macros.svh
// Assertion macros for the rotate-in-place heading controller.
`ifndef ROTATE_IN_PLACE_HEADING_CONTROLLER_MACROS_SVH
`define ROTATE_IN_PLACE_HEADING_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define RIP_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RIP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define RIP_ASSERT_IMPL(label, clk, rst_n, a, c)
`define RIP_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### sv/riphc_pkg.sv
// ----------------------------------------------------------------------------
// riphc_pkg
// Shared constants, types and the arctangent table.
// ----------------------------------------------------------------------------
package riphc_pkg;
    localparam int ATAN_STEPS_DEF = 16;
    localparam logic [1:0] MODE_HEADING = 2'd0;
    localparam logic [1:0] MODE_PATH    = 2'd1;
    localparam logic [1:0] MODE_DEFER   = 2'd2;
    localparam logic signed [18:0] HALF_PI_Q = 19'sd102944;

    localparam logic [2:0] REG_ACCEL   = 3'd0;
    localparam logic [2:0] REG_SPIN    = 3'd1;
    localparam logic [2:0] REG_TOPLIN  = 3'd2;
    localparam logic [2:0] REG_PATHLIM = 3'd3;
    localparam logic [2:0] REG_ARRIVE  = 3'd4;
    localparam logic [2:0] REG_HEADTOL = 3'd5;
    localparam logic [2:0] REG_TICK    = 3'd6;
    localparam logic [2:0] REG_FEAT    = 3'd7;

    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0: v = 16'd51472;  5'd1: v = 16'd30385;
            5'd2: v = 16'd16055;  5'd3: v = 16'd8150;
            5'd4: v = 16'd4091;   5'd5: v = 16'd2047;
            5'd6: v = 16'd1024;   5'd7: v = 16'd512;
            5'd8: v = 16'd256;    5'd9: v = 16'd128;
            5'd10: v = 16'd64;    5'd11: v = 16'd32;
            5'd12: v = 16'd16;    5'd13: v = 16'd8;
            5'd14: v = 16'd4;     5'd15: v = 16'd2;
            5'd16: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;
endpackage

### sv/riphc_if.sv
// ----------------------------------------------------------------------------
// riphc_in_if / riphc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface riphc_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [18:0] goal_heading;
    logic signed [31:0] forward_speed;
    logic signed [31:0] fallback_turn;
    modport source (output valid, aim_x, aim_y, goal_heading, forward_speed,
                    fallback_turn, input ready);
    modport sink (input valid, aim_x, aim_y, goal_heading, forward_speed,
                  fallback_turn, output ready);
endinterface

interface riphc_out_if;
    logic valid;
    logic ready;
    logic [1:0] mode;
    logic signed [31:0] turn_cmd;
    logic zero_linear;
    modport source (output valid, mode, turn_cmd, zero_linear, input ready);
    modport sink (input valid, mode, turn_cmd, zero_linear, output ready);
endinterface

### sv/riphc_div.sv
// ----------------------------------------------------------------------------
// riphc_div
// Restoring divider, one quotient bit per cycle, 64 by 64 bits.
// ----------------------------------------------------------------------------
module riphc_div
    import riphc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_q, n_q, r_rem, n_rem, r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [64:0] w_sh;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_rem, r_q[63]};
        if (i_req.start) begin
            n_q = i_req.num; n_rem = '0; n_den = i_req.den;
            n_cnt = 7'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = 64'(w_sh - {1'b0, r_den});
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_sh[63:0];
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### sv/rotate_in_place_heading_controller.sv
// ----------------------------------------------------------------------------
// rotate_in_place_heading_controller
// Per-tick choice between rotate to heading, rotate to path and defer.
// ----------------------------------------------------------------------------
// One word in, one word out. A word that defers inside the arrival radius
// passes only the squared range check; a word that lies outside the radius
// with dynamic scaling on and then rotates toward the path also runs the
// bearing, the speed scaling, the stopping angle and the window step, and its
// result may wait on the output. The squared range check and window step use
// a shared 32x32 multiplier, the bearing runs ATAN_STEPS CORDIC iterations,
// and the speed scaling and stopping angle each run on a bit-serial divider.
// The input is not ready while a word is in work or its result waits.
`include "rotate_in_place_heading_controller_macros.svh"
module rotate_in_place_heading_controller
    import riphc_pkg::*;
#(
    parameter int ATAN_STEPS = ATAN_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    riphc_in_if.sink    in_ch,
    riphc_out_if.source out_ch
);
    localparam int SW = $clog2(ATAN_STEPS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MX    = 5'd1;
    localparam logic [4:0] S_MY    = 5'd2;
    localparam logic [4:0] S_ARR   = 5'd3;
    localparam logic [4:0] S_CPRE  = 5'd4;
    localparam logic [4:0] S_CIT   = 5'd5;
    localparam logic [4:0] S_DMUL  = 5'd6;
    localparam logic [4:0] S_DDIV  = 5'd7;
    localparam logic [4:0] S_DWAIT = 5'd8;
    localparam logic [4:0] S_THR   = 5'd9;
    localparam logic [4:0] S_PSQ   = 5'd10;
    localparam logic [4:0] S_SDIV  = 5'd11;
    localparam logic [4:0] S_SWAIT = 5'd12;
    localparam logic [4:0] S_STEP  = 5'd13;
    localparam logic [4:0] S_CLAMP = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;

    // configuration
    logic [30:0] r_accel, r_spin, r_toplin, r_pathlim, r_arrive, r_headtol;
    logic [16:0] r_tick;
    logic [2:0]  r_feat;
    logic [2:0]  w_ridx;

    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= 31'd78643; r_spin <= 31'd98304; r_toplin <= 31'd17039;
            r_pathlim <= 31'd51446; r_arrive <= 31'd16384;
            r_headtol <= 31'd16384; r_tick <= 17'd3277; r_feat <= 3'd7;
        end else if (psel && penable && pwrite) begin
            case (w_ridx)
                REG_ACCEL:   r_accel   <= pwdata[30:0];
                REG_SPIN:    r_spin    <= pwdata[30:0];
                REG_TOPLIN:  r_toplin  <= pwdata[30:0];
                REG_PATHLIM: r_pathlim <= pwdata[30:0];
                REG_ARRIVE:  r_arrive  <= pwdata[30:0];
                REG_HEADTOL: r_headtol <= pwdata[30:0];
                REG_TICK:    r_tick    <= pwdata[16:0];
                REG_FEAT:    r_feat    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            REG_ACCEL:   prdata = {1'b0, r_accel};
            REG_SPIN:    prdata = {1'b0, r_spin};
            REG_TOPLIN:  prdata = {1'b0, r_toplin};
            REG_PATHLIM: prdata = {1'b0, r_pathlim};
            REG_ARRIVE:  prdata = {1'b0, r_arrive};
            REG_HEADTOL: prdata = {1'b0, r_headtol};
            REG_TICK:    prdata = {15'd0, r_tick};
            REG_FEAT:    prdata = {29'd0, r_feat};
            default:     prdata = '0;
        endcase
    end

    // datapath registers
    logic [4:0]  r_st, n_st;
    logic signed [31:0] r_ax, r_ay, r_last;
    logic signed [18:0] r_goal;
    logic [31:0] r_spd;
    logic signed [63:0] r_cx, r_cy;
    logic signed [19:0] r_z;
    logic [SW-1:0] r_it;
    logic [63:0] r_acc;     // multiplier accumulator
    logic [63:0] r_thr;
    logic signed [32:0] r_tgt;
    logic signed [33:0] r_cmd;
    logic [32:0] r_step;
    logic [1:0]  r_mode;
    logic signed [31:0] r_out;

    // shared multiplier, 32x32 unsigned
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic [31:0] w_ux, w_uy, w_plast;
    logic [32:0] w_tmag;
    assign w_ux = r_ax[31] ? 32'(-r_ax) : 32'(r_ax);
    assign w_uy = r_ay[31] ? 32'(-r_ay) : 32'(r_ay);
    assign w_plast = r_last[31] ? 32'(-r_last) : 32'(r_last);
    assign w_tmag = r_tgt[32] ? 33'(-r_tgt) : 33'(r_tgt);

    always_comb begin
        w_ma = '0; w_mb = '0;
        case (r_st)
            S_MX:   begin w_ma = w_ux; w_mb = w_ux; end
            S_MY:   begin w_ma = w_uy; w_mb = w_uy; end
            S_ARR:  begin w_ma = {1'b0, r_arrive}; w_mb = {1'b0, r_arrive}; end
            S_DMUL: begin w_ma = {1'b0, r_pathlim}; w_mb = r_spd; end
            S_PSQ:  begin w_ma = w_plast; w_mb = w_plast; end
            S_STEP: begin w_ma = {1'b0, r_accel}; w_mb = {15'd0, r_tick}; end
            default: ;
        endcase
    end

    // divider
    t_div_req    w_dreq;
    logic        w_ddone;
    logic [63:0] w_quot;

    always_comb begin
        w_dreq.start = (r_st == S_DDIV) || (r_st == S_SDIV);
        w_dreq.num = r_acc;
        w_dreq.den = (r_st == S_SDIV) ? {32'd0, r_accel, 1'b0} : {33'd0, r_toplin};
    end

    riphc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
        .o_done(w_ddone), .o_quot(w_quot)
    );

    // CORDIC start vector, coordinates scaled by 2^28
    logic signed [63:0] w_px, w_py;
    assign w_px = {{4{r_ax[31]}}, r_ax, 28'd0};
    assign w_py = {{4{r_ay[31]}}, r_ay, 28'd0};

    // CORDIC step
    logic signed [63:0] w_dx, w_dy;
    logic [4:0] w_it5;
    assign w_it5 = 5'(r_it);
    assign w_dx = r_cy >>> r_it;
    assign w_dy = r_cx >>> r_it;

    logic signed [20:0] w_amag;
    assign w_amag = r_z[19] ? -21'(r_z) : 21'(r_z);

    logic w_accept;
    assign in_ch.ready = (r_st == S_IDLE);
    assign w_accept = in_ch.valid && in_ch.ready;

    logic [64:0] w_stop;
    assign w_stop = {1'b0, w_quot} + {34'd0, r_headtol};

    logic signed [33:0] w_lo, w_hi, w_cand;
    assign w_lo = 34'(r_last) - 34'(r_step);
    assign w_hi = 34'(r_last) + 34'(r_step);
    assign w_cand = (r_cmd < w_lo) ? w_lo : ((r_cmd > w_hi) ? w_hi : r_cmd);

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (w_accept) n_st = S_MX;
            S_MX:    n_st = S_MY;
            S_MY:    n_st = S_ARR;
            S_ARR:   begin
                if (r_acc < w_prod)
                    n_st = r_feat[0] ? S_PSQ : S_OUT;
                else
                    n_st = S_CPRE;
            end
            S_CPRE:  n_st = S_CIT;
            S_CIT:   if (r_it == SW'(ATAN_STEPS - 1)) n_st = r_feat[2] ? S_DMUL : S_THR;
            S_DMUL:  n_st = (r_toplin == 31'd0) ? S_THR : S_DDIV;
            S_DDIV:  n_st = S_DWAIT;
            S_DWAIT: if (w_ddone) n_st = S_THR;
            S_THR:   n_st = ({43'd0, w_amag[20:0]} > r_thr && r_feat[1]) ? S_PSQ : S_OUT;
            S_PSQ:   n_st = (r_accel == 31'd0) ? S_STEP : S_SDIV;
            S_SDIV:  n_st = S_SWAIT;
            S_SWAIT: if (w_ddone) n_st = S_STEP;
            S_STEP:  n_st = S_CLAMP;
            S_CLAMP: n_st = S_OUT;
            S_OUT:   if (out_ch.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_last <= '0;
        end else begin
            r_st <= n_st;
            // last_turn follows every delivered word, deferred ones too
            if (r_st == S_OUT && out_ch.ready) r_last <= r_out;
        end
        case (r_st)
            S_IDLE: begin
                r_ax <= in_ch.aim_x; r_ay <= in_ch.aim_y;
                r_goal <= in_ch.goal_heading;
                r_spd <= in_ch.forward_speed[31] ? 32'(-in_ch.forward_speed)
                                                 : 32'(in_ch.forward_speed);
                r_out <= in_ch.fallback_turn; r_mode <= MODE_DEFER;
            end
            S_MX: r_acc <= w_prod;
            S_MY: r_acc <= r_acc + w_prod;
            S_ARR: begin
                r_tgt <= 33'(r_goal);
                if (r_acc < w_prod && r_feat[0]) r_mode <= MODE_HEADING;
            end
            S_CPRE: begin
                r_it <= '0;
                if (r_ax[31]) begin
                    if (!r_ay[31]) begin
                        r_cx <= w_py; r_cy <= -w_px;
                        r_z <= 20'(HALF_PI_Q);
                    end else begin
                        r_cx <= -w_py; r_cy <= w_px;
                        r_z <= -20'(HALF_PI_Q);
                    end
                end else begin
                    r_cx <= w_px; r_cy <= w_py;
                    r_z <= '0;
                end
                r_thr <= {33'd0, r_pathlim};
            end
            S_CIT: begin
                r_it <= r_it + SW'(1);
                if (!r_cy[63]) begin
                    r_cx <= r_cx + w_dx; r_cy <= r_cy - w_dy;
                    r_z <= r_z + 20'(atan_entry(w_it5));
                end else begin
                    r_cx <= r_cx - w_dx; r_cy <= r_cy + w_dy;
                    r_z <= r_z - 20'(atan_entry(w_it5));
                end
                // the origin has bearing zero
                if (r_ax == 32'sd0 && r_ay == 32'sd0) r_z <= '0;
            end
            S_DMUL: begin
                r_acc <= w_prod;
                // zero top speed: unbounded threshold
                if (r_toplin == 31'd0) r_thr <= '1;
            end
            S_DWAIT: if (w_ddone)
                r_thr <= (w_quot > {33'd0, r_headtol}) ? w_quot : {33'd0, r_headtol};
            S_THR: begin
                r_tgt <= 33'(r_z);
                if ({43'd0, w_amag[20:0]} > r_thr && r_feat[1]) r_mode <= MODE_PATH;
            end
            S_PSQ: begin
                r_acc <= w_prod;
                r_cmd <= (r_tgt > 33'sd0) ? 34'(r_spin) : -34'(r_spin);
                if (r_accel == 31'd0) r_cmd <= '0;
            end
            S_SWAIT: if (w_ddone && w_stop > {32'd0, w_tmag})
                r_cmd <= '0;
            S_STEP: r_step <= 33'(w_prod >> 16);
            S_CLAMP: r_out <= 32'(w_cand);
            default: ;
        endcase
    end

    assign out_ch.valid = (r_st == S_OUT);
    assign out_ch.mode = r_mode;
    assign out_ch.turn_cmd = r_out;
    assign out_ch.zero_linear = (r_mode != MODE_DEFER);

    `RIP_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_st != S_IDLE, !in_ch.ready)
    `RIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(r_out) && $stable(r_mode))
    `RIP_ASSERT_IMPL(a_mode_legal, i_clk, i_rst_n, out_ch.valid, (r_mode == MODE_HEADING) || (r_mode == MODE_PATH) || (r_mode == MODE_DEFER))
    `RIP_ASSERT_NEXT(a_last_follows, i_clk, i_rst_n, out_ch.valid && out_ch.ready, r_last == $past(r_out))
endmodule

### dv/tb_rotate_in_place_heading_controller.sv
// ----------------------------------------------------------------------------
// tb_rotate_in_place_heading_controller
// Self-checking bench: drives control-tick words through the input channel,
// predicts mode, turn command and linear-zero flag per word, and compares
// every result word against the oldest prediction across several register
// settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotate_in_place_heading_controller
    import riphc_pkg::*;
;

    localparam int  NUM_PHASES  = 6;
    localparam int  RAND_WORDS  = 150;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [18:0] goal_heading;
        logic signed [31:0] forward_speed;
        logic signed [31:0] fallback_turn;
    } t_tick;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] turn_cmd;
        logic               zero_linear;
    } t_decision;

    typedef struct {
        logic [30:0] accel_limit;
        logic [30:0] spin_speed;
        logic [30:0] top_linear_speed;
        logic [30:0] path_angle_limit;
        logic [30:0] arrive_distance;
        logic [30:0] heading_tolerance;
        logic [16:0] tick_period;
        logic [2:0]  feature_enables;
    } t_regs;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    riphc_in_if  in_ch ();
    riphc_out_if out_ch ();

    rotate_in_place_heading_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    t_regs              regs;
    longint signed      prev_turn;
    t_tick              tick_queue[$];
    t_decision          decision_queue[$];
    logic               steady;
    int                 mismatches;
    int                 words_in;
    int                 words_out;
    int                 heading_cnt;
    int                 path_cnt;
    int                 defer_cnt;
    longint             cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint signed atan_tab(input int i);
        case (i)
            0: return 51472;  1: return 30385;  2: return 16055;  3: return 8150;
            4: return 4091;   5: return 2047;   6: return 1024;   7: return 512;
            8: return 256;    9: return 128;    10: return 64;    11: return 32;
            12: return 16;    13: return 8;     14: return 4;     15: return 2;
            16: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint signed cordic_bearing(input longint signed ax,
                                                     input longint signed ay);
        longint signed x;
        longint signed y;
        longint signed z;
        longint signed nx;
        longint signed dx;
        longint signed dy;
        z = 0;
        if (ax == 0 && ay == 0) return 0;
        x = ax * 64'sd268435456;
        y = ay * 64'sd268435456;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; y = -x; x = nx; z = HALF_PI_Q;
            end else begin
                nx = -y; y = x; x = nx; z = -HALF_PI_Q;
            end
        end
        for (int i = 0; i < ATAN_STEPS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab(i);
            end else begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint signed limited_spin(input longint signed target);
        longint unsigned mag;
        longint unsigned p;
        longint unsigned stop;
        longint signed   cmd;
        longint signed   step;
        longint signed   lo;
        longint signed   hi;
        mag = (target < 0) ? -target : target;
        p   = (prev_turn < 0) ? -prev_turn : prev_turn;
        cmd = (target > 0) ? longint'(regs.spin_speed) : -longint'(regs.spin_speed);
        if (regs.accel_limit == 0) begin
            cmd = 0;
        end else begin
            stop = (p * p) / (2 * longint'(regs.accel_limit)) + regs.heading_tolerance;
            if (stop > mag) cmd = 0;
        end
        step = (longint'(regs.accel_limit) * longint'(regs.tick_period)) >>> 16;
        lo = prev_turn - step;
        hi = prev_turn + step;
        if (cmd < lo) cmd = lo;
        if (cmd > hi) cmd = hi;
        return cmd;
    endfunction

    function automatic t_decision decide(input t_tick t);
        t_decision       d;
        longint signed   ax;
        longint signed   ay;
        longint signed   spd;
        longint signed   ang;
        longint signed   cmd;
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned amag;
        longint unsigned thresh;
        longint unsigned dyn;
        ax  = t.aim_x;
        ay  = t.aim_y;
        spd = t.forward_speed;
        cmd = t.fallback_turn;
        d.mode = MODE_DEFER;
        d.zero_linear = 1'b0;
        ux = (ax < 0) ? -ax : ax;
        uy = (ay < 0) ? -ay : ay;
        if (ux * ux + uy * uy <
            longint'(regs.arrive_distance) * longint'(regs.arrive_distance)) begin
            if (regs.feature_enables[0]) begin
                cmd = limited_spin(t.goal_heading);
                d.mode = MODE_HEADING;
                d.zero_linear = 1'b1;
            end
        end else begin
            thresh = regs.path_angle_limit;
            ang  = cordic_bearing(ax, ay);
            amag = (ang < 0) ? -ang : ang;
            if (regs.feature_enables[2]) begin
                // zero top speed saturates the scaled threshold
                if (regs.top_linear_speed == 0) dyn = '1;
                else dyn = (longint'(regs.path_angle_limit) *
                            ((spd < 0) ? -spd : spd)) / regs.top_linear_speed;
                thresh = (dyn > regs.heading_tolerance) ? dyn : regs.heading_tolerance;
            end
            if (amag > thresh && regs.feature_enables[1]) begin
                cmd = limited_spin(ang);
                d.mode = MODE_PATH;
                d.zero_linear = 1'b1;
            end
        end
        prev_turn = cmd;
        d.turn_cmd = cmd[31:0];
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tick t;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                t.aim_x         = in_ch.aim_x;
                t.aim_y         = in_ch.aim_y;
                t.goal_heading  = in_ch.goal_heading;
                t.forward_speed = in_ch.forward_speed;
                t.fallback_turn = in_ch.fallback_turn;
                decision_queue.push_back(decide(t));
                words_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tick_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 21)) begin
                    t = tick_queue.pop_front();
                    in_ch.aim_x         <= t.aim_x;
                    in_ch.aim_y         <= t.aim_y;
                    in_ch.goal_heading  <= t.goal_heading;
                    in_ch.forward_speed <= t.forward_speed;
                    in_ch.fallback_turn <= t.fallback_turn;
                    in_ch.valid         <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_decision e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** rotate_in_place_heading_controller: FAILED **");
            $finish;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                words_out++;
                if (decision_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: mode %0d turn %0d",
                                 out_ch.mode, out_ch.turn_cmd);
                end else begin
                    e = decision_queue.pop_front();
                    case (e.mode)
                        MODE_HEADING: heading_cnt++;
                        MODE_PATH:    path_cnt++;
                        default:      defer_cnt++;
                    endcase
                    if (out_ch.mode !== e.mode || out_ch.turn_cmd !== e.turn_cmd ||
                        out_ch.zero_linear !== e.zero_linear) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: expected mode %0d turn %0d zl %0b, got %0d %0d %0b",
                                     words_out, e.mode, e.turn_cmd, e.zero_linear,
                                     out_ch.mode, out_ch.turn_cmd, out_ch.zero_linear);
                    end
                end
            end
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ACCEL:   regs.accel_limit       = value[30:0];
            REG_SPIN:    regs.spin_speed        = value[30:0];
            REG_TOPLIN:  regs.top_linear_speed  = value[30:0];
            REG_PATHLIM: regs.path_angle_limit  = value[30:0];
            REG_ARRIVE:  regs.arrive_distance   = value[30:0];
            REG_HEADTOL: regs.heading_tolerance = value[30:0];
            REG_TICK:    regs.tick_period       = value[16:0];
            REG_FEAT:    regs.feature_enables   = value[2:0];
            default: ;
        endcase
    endtask

    task automatic send(input logic signed [31:0] x, input logic signed [31:0] y,
                        input logic signed [18:0] g, input logic signed [31:0] s,
                        input logic signed [31:0] f);
        t_tick t;
        t.aim_x = x; t.aim_y = y; t.goal_heading = g;
        t.forward_speed = s; t.fallback_turn = f;
        tick_queue.push_back(t);
    endtask

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic logic signed [18:0] rand_heading();
        return 19'($signed($urandom_range(0, 411774)) - 205887);
    endfunction

    task automatic drain();
        wait (tick_queue.size() == 0 && !in_ch.valid && decision_queue.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic random_ticks(input int n);
        int span;
        span = regs.arrive_distance / 2;
        for (int k = 0; k < n; k++) begin
            if (span > 0 && $urandom_range(0, 99) < 35)
                send($signed($urandom_range(0, 2 * span)) - span,
                     $signed($urandom_range(0, 2 * span)) - span,
                     rand_heading(), rand_word(), rand_word());
            else
                send(rand_word(), rand_word(), rand_heading(), rand_word(), rand_word());
        end
    endtask

    initial begin
        regs.accel_limit       = 31'd78643;
        regs.spin_speed        = 31'd98304;
        regs.top_linear_speed  = 31'd17039;
        regs.path_angle_limit  = 31'd51446;
        regs.arrive_distance   = 31'd16384;
        regs.heading_tolerance = 31'd16384;
        regs.tick_period       = 17'd3277;
        regs.feature_enables   = 3'd7;
        prev_turn   = 0;
        mismatches  = 0;
        words_in    = 0;
        words_out   = 0;
        heading_cnt = 0;
        path_cnt    = 0;
        defer_cnt   = 0;
        cycles      = 0;
        steady      = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_ch.valid         = 1'b0;
        in_ch.aim_x         = '0;
        in_ch.aim_y         = '0;
        in_ch.goal_heading  = '0;
        in_ch.forward_speed = '0;
        in_ch.fallback_turn = '0;
        out_ch.ready        = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings
        send(0, 0, 0, 0, 0);                              // origin
        send(0, 0, 19'sd205887, 0, 32'sh7FFFFFFF);        // inside, max heading
        send(100, -100, -19'sd205887, 0, 0);              // inside, min heading
        send(0, 0, 19'sd205887, 0, 0);
        send(0, 0, 0, 0, 32'sh80000000);                  // inside, heading in tolerance
        send(32'sh80000000, 32'sh80000000, 0, 0, 5);
        send(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 7);
        send(32'sh80000000, 0, 0, 0, -3);                 // straight behind
        send(32'sh80000000, 1, 0, 32'sh80000000, 0);
        send(-65536, -1, 0, 0, 0);
        send(0, 65536, 0, 0, 0);                          // pure left
        send(0, -65536, 0, 0, 0);
        send(65536, 0, 0, 0, 32'sh80000000);              // dead ahead: defer
        send(65536, 65536, 0, 32'sh7FFFFFFF, 1);          // high speed widens threshold
        send(65536, 65536, 0, 32'sh80000000, 1);
        send(65536, 70000, 0, 0, 0);
        send(16384, 0, 0, 0, 0);                          // exactly on the arrival radius
        send(16383, 0, 19'sd100000, 0, 0);
        random_ticks(RAND_WORDS);
        drain();

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(REG_ACCEL, 32'h7FFFFFFF);
                    write_reg(REG_SPIN, 32'h7FFFFFFF);
                    write_reg(REG_TOPLIN, 0);
                    write_reg(REG_PATHLIM, 0);
                    write_reg(REG_ARRIVE, 32'h7FFFFFFF);
                    write_reg(REG_HEADTOL, 0);
                    write_reg(REG_TICK, 32'h1FFFF);
                    write_reg(REG_FEAT, 3'd7);
                end
                2: begin
                    write_reg(REG_ACCEL, 1);
                    write_reg(REG_ARRIVE, 32'd300000);
                    write_reg(REG_TOPLIN, 32'h7FFFFFFF);
                    write_reg(REG_PATHLIM, 32'h7FFFFFFF);
                    write_reg(REG_HEADTOL, 32'h7FFFFFFF);
                    write_reg(REG_TICK, 0);
                    write_reg(REG_FEAT, 3'd5);
                end
                3: begin
                    write_reg(REG_ACCEL, 0);
                    write_reg(REG_SPIN, 0);
                    write_reg(REG_TICK, 32'd65536);
                    write_reg(REG_FEAT, 3'd0);
                    write_reg(REG_ARRIVE, 0);
                end
                default: begin
                    write_reg(REG_ACCEL, $urandom_range(1, 32'h7FFFFFFF));
                    write_reg(REG_SPIN, $urandom_range(0, 500000));
                    write_reg(REG_TOPLIN, $urandom_range(0, 200000));
                    write_reg(REG_PATHLIM, $urandom_range(0, 205887));
                    write_reg(REG_ARRIVE, $urandom_range(0, 200000));
                    write_reg(REG_HEADTOL, $urandom_range(0, 60000));
                    write_reg(REG_TICK, $urandom_range(0, 65536));
                    write_reg(REG_FEAT, $urandom_range(2, 7));
                end
            endcase
            // one phase runs with both sides at full rate
            steady = (ph == 2);
            random_ticks(RAND_WORDS);
            drain();
        end
        steady = 1'b0;

        repeat (300) @(posedge i_clk);
        $display("covered %0d words: %0d rotate-to-heading, %0d rotate-to-path, %0d deferred",
                 words_in, heading_cnt, path_cnt, defer_cnt);
        $display("over %0d register settings including range extremes", NUM_PHASES);
        if (mismatches == 0 && decision_queue.size() == 0) begin
            $display("** rotate_in_place_heading_controller: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, decision_queue.size());
            $display("** rotate_in_place_heading_controller: FAILED **");
        end
        $finish;
    end

endmodule
